FILE: design/cst_pkg.sv
// shared types and constants for the c subset tokenizer
// no dependencies; imported by cst_front, cst_back and c_subset_tokenizer
`timescale 1ns / 1ps

package cst_pkg;

  // result kinds
  localparam logic [4:0] K_EOF    = 5'd0;
  localparam logic [4:0] K_IDENT  = 5'd1;
  localparam logic [4:0] K_NUM    = 5'd2;
  localparam logic [4:0] K_INT    = 5'd3;
  localparam logic [4:0] K_LBRACE = 5'd9;
  localparam logic [4:0] K_RBRACE = 5'd10;
  localparam logic [4:0] K_LPAREN = 5'd11;
  localparam logic [4:0] K_RPAREN = 5'd12;
  localparam logic [4:0] K_SEMI   = 5'd13;
  localparam logic [4:0] K_PLUS   = 5'd14;
  localparam logic [4:0] K_MINUS  = 5'd15;
  localparam logic [4:0] K_STAR   = 5'd16;
  localparam logic [4:0] K_SLASH  = 5'd17;
  localparam logic [4:0] K_ASSIGN = 5'd18;
  localparam logic [4:0] K_EQ     = 5'd19;
  localparam logic [4:0] K_NE     = 5'd20;
  localparam logic [4:0] K_LT     = 5'd21;
  localparam logic [4:0] K_GT     = 5'd22;
  localparam logic [4:0] K_LE     = 5'd23;
  localparam logic [4:0] K_GE     = 5'd24;
  localparam logic [4:0] K_ICHAR  = 5'd25;
  localparam logic [4:0] K_ERR    = 5'd26;

  // command codes
  localparam logic CMD_CHAR = 1'b0;
  localparam logic CMD_END  = 1'b1;

  // source bytes
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LZ     = 8'h7A;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UZ     = 8'h5A;
  localparam logic [7:0] CH_USCORE = 8'h5F;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_LESS   = 8'h3C;
  localparam logic [7:0] CH_GREAT  = 8'h3E;

  // keywords: int if else while print return, packed big-endian
  localparam int KW_NUM     = 6;
  localparam int KW_MAX_LEN = 6;
  localparam logic [47:0] KW_TEXT [KW_NUM] = '{
    48'h000000696E74, 48'h000000006966, 48'h0000656C7365,
    48'h007768696C65, 48'h007072696E74, 48'h72657475726E
  };
  localparam logic [2:0] KW_LEN [KW_NUM] = '{3'd3, 3'd2, 3'd4, 3'd5, 3'd5, 3'd6};

  typedef enum logic [3:0] {
    CL_SPACE, CL_NL, CL_DIGIT, CL_ALPHA, CL_PUNCT,
    CL_EQ, CL_BANG, CL_LT, CL_GT, CL_BAD
  } cls_e;

  typedef enum logic [7:0] {
    MODE_IDLE   = 8'b0000_0001,
    MODE_NUM    = 8'b0000_0010,
    MODE_IDENT  = 8'b0000_0100,
    MODE_EQ     = 8'b0000_1000,
    MODE_BANG   = 8'b0001_0000,
    MODE_LT     = 8'b0010_0000,
    MODE_GT     = 8'b0100_0000,
    MODE_SILENT = 8'b1000_0000
  } mode_e;

  // classified word between front and back
  typedef struct packed {
    logic       cmd;
    logic [7:0] ch;
    cls_e       cls;
    logic [4:0] pkind;
  } item_t;

  typedef struct packed {
    logic [4:0]  kind;
    logic [31:0] number;
    logic [7:0]  text_char;
    logic [15:0] line;
    logic        last;
  } res_t;

endpackage

FILE: design/cst_fifo.sv
// small register queue with push/full and pop/empty sides
// no dependencies; used by cst_front and cst_back
`timescale 1ns / 1ps

module cst_fifo #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);
  localparam logic [AW-1:0] LastIdx = AW'(Depth - 1);
  localparam logic [CW-1:0] DepthC  = CW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [AW-1:0]    wptr_q, rptr_q;
  logic [CW-1:0]    cnt_q;
  logic             push_en, pop_en;

  assign full_o  = (cnt_q == DepthC);
  assign empty_o = (cnt_q == '0);
  assign push_en = push_i && !full_o;
  assign pop_en  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_en) wptr_q <= (wptr_q == LastIdx) ? '0 : wptr_q + 1'b1;
      if (pop_en)  rptr_q <= (rptr_q == LastIdx) ? '0 : rptr_q + 1'b1;
      if (push_en && !pop_en) cnt_q <= cnt_q + 1'b1;
      else if (pop_en && !push_en) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_en) mem_q[wptr_q] <= wdata_i;
  end

endmodule

FILE: design/cst_front.sv
// front end: classifies each source byte and queues the word for the scanner
// depends on cst_pkg and cst_fifo
`timescale 1ns / 1ps

module cst_front import cst_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  logic       cmd_i,
  input  logic [7:0] ch_i,
  output logic       full_o,
  input  logic       pop_i,
  output item_t      item_o,
  output logic       empty_o
);

  item_t item_d;

  always_comb begin
    item_d.cmd   = cmd_i;
    item_d.ch    = ch_i;
    item_d.pkind = K_EOF;
    item_d.cls   = CL_BAD;
    if (ch_i >= CH_0 && ch_i <= CH_9) begin
      item_d.cls = CL_DIGIT;
    end else if ((ch_i >= CH_LA && ch_i <= CH_LZ) || (ch_i >= CH_UA && ch_i <= CH_UZ) ||
                 ch_i == CH_USCORE) begin
      item_d.cls = CL_ALPHA;
    end else begin
      unique case (ch_i)
        CH_NL:     item_d.cls = CL_NL;
        CH_SPACE, CH_TAB, CH_CR: item_d.cls = CL_SPACE;
        CH_EQUAL:  item_d.cls = CL_EQ;
        CH_BANG:   item_d.cls = CL_BANG;
        CH_LESS:   item_d.cls = CL_LT;
        CH_GREAT:  item_d.cls = CL_GT;
        CH_LBRACE: begin item_d.cls = CL_PUNCT; item_d.pkind = K_LBRACE; end
        CH_RBRACE: begin item_d.cls = CL_PUNCT; item_d.pkind = K_RBRACE; end
        CH_LPAREN: begin item_d.cls = CL_PUNCT; item_d.pkind = K_LPAREN; end
        CH_RPAREN: begin item_d.cls = CL_PUNCT; item_d.pkind = K_RPAREN; end
        CH_SEMI:   begin item_d.cls = CL_PUNCT; item_d.pkind = K_SEMI; end
        CH_PLUS:   begin item_d.cls = CL_PUNCT; item_d.pkind = K_PLUS; end
        CH_MINUS:  begin item_d.cls = CL_PUNCT; item_d.pkind = K_MINUS; end
        CH_STAR:   begin item_d.cls = CL_PUNCT; item_d.pkind = K_STAR; end
        CH_SLASH:  begin item_d.cls = CL_PUNCT; item_d.pkind = K_SLASH; end
        default:   item_d.cls = CL_BAD;
      endcase
    end
  end

  cst_fifo #(
    .Width($bits(item_t)),
    .Depth(2)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push_i),
    .wdata_i(item_d),
    .full_o (full_o),
    .pop_i  (pop_i),
    .rdata_o(item_o),
    .empty_o(empty_o)
  );

endmodule

FILE: design/cst_back.sv
// back end: scanner state machine, emits up to two results per word
// depends on cst_pkg and cst_fifo
`timescale 1ns / 1ps

module cst_back import cst_pkg::*; #(
  parameter int MAX_IDENT_CHARS = 31
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  item_t item_i,
  input  logic  item_empty_i,
  output logic  item_pop_o,
  input  logic  pop_i,
  output res_t  res_o,
  output logic  empty_o
);

  localparam int LenW = $clog2(MAX_IDENT_CHARS + 1);
  localparam logic [LenW-1:0] MaxLen = LenW'(MAX_IDENT_CHARS);
  localparam logic [LenW-1:0] KwLen  = LenW'(KW_MAX_LEN);

  mode_e           mode_q, mode_d, f_mode;
  logic [31:0]     acc_q, acc_d, f_acc;
  logic [LenW-1:0] ilen_q, ilen_d, f_ilen;
  logic [47:0]     kwin_q, kwin_d, f_kwin;
  logic [15:0]     line_q, line_d, f_line;
  logic [15:0]     tline_q, tline_d, f_tline;
  logic            phase_q, phase_d;

  res_t f_res, close_res, tail_res, wr_res;
  logic f_v, close_v, tail_v;
  logic [4:0] id_kind;
  logic wr_last, out_full, out_push, item_valid;

  assign item_valid = !item_empty_i;

  // keyword match on the closing identifier
  always_comb begin
    id_kind = K_IDENT;
    for (int i = KW_NUM - 1; i >= 0; i--) begin
      if (ilen_q == LenW'(KW_LEN[i]) && kwin_q == KW_TEXT[i]) id_kind = K_INT + 5'(i);
    end
  end

  // start of a new token from this byte
  always_comb begin
    f_mode  = MODE_IDLE;
    f_acc   = acc_q;
    f_ilen  = ilen_q;
    f_kwin  = kwin_q;
    f_line  = line_q;
    f_tline = line_q;
    f_v     = 1'b0;
    f_res   = '0;
    f_res.line = line_q;
    unique case (item_i.cls)
      CL_NL:    if (line_q != 16'hFFFF) f_line = line_q + 16'd1;
      CL_SPACE: ;
      CL_DIGIT: begin
        f_mode = MODE_NUM;
        f_acc  = {28'd0, item_i.ch[3:0]};
      end
      CL_ALPHA: begin
        f_mode = MODE_IDENT;
        f_ilen = LenW'(1);
        f_kwin = {40'd0, item_i.ch};
        f_v    = 1'b1;
        f_res.kind      = K_ICHAR;
        f_res.text_char = item_i.ch;
      end
      CL_PUNCT: begin
        f_v        = 1'b1;
        f_res.kind = item_i.pkind;
      end
      CL_EQ:   f_mode = MODE_EQ;
      CL_BANG: f_mode = MODE_BANG;
      CL_LT:   f_mode = MODE_LT;
      CL_GT:   f_mode = MODE_GT;
      default: begin
        f_mode     = MODE_SILENT;
        f_v        = 1'b1;
        f_res.kind = K_ERR;
      end
    endcase
  end

  always_comb begin
    mode_d  = mode_q;
    acc_d   = acc_q;
    ilen_d  = ilen_q;
    kwin_d  = kwin_q;
    line_d  = line_q;
    tline_d = tline_q;
    close_v = 1'b0;
    tail_v  = 1'b0;
    close_res = '0;
    close_res.line = tline_q;
    tail_res  = '0;
    tail_res.line  = tline_q;
    if (item_i.cmd == CMD_END) begin
      close_v = 1'b1;
      unique case (mode_q)
        MODE_NUM: begin
          close_res.kind   = K_NUM;
          close_res.number = acc_q;
        end
        MODE_IDENT: close_res.kind = id_kind;
        MODE_EQ:    close_res.kind = K_ASSIGN;
        MODE_LT:    close_res.kind = K_LT;
        MODE_GT:    close_res.kind = K_GT;
        MODE_BANG:  close_res.kind = K_ERR;
        default:    close_v = 1'b0;
      endcase
      tail_v        = 1'b1;
      tail_res.kind = K_EOF;
      tail_res.line = line_q;
      mode_d  = MODE_IDLE;
      acc_d   = '0;
      ilen_d  = '0;
      kwin_d  = '0;
      line_d  = 16'd1;
      tline_d = 16'd1;
    end else begin
      unique case (mode_q)
        MODE_SILENT: ;
        MODE_NUM: begin
          if (item_i.cls == CL_DIGIT) begin
            // times ten as two shifts and an add
            acc_d = (acc_q << 3) + (acc_q << 1) + {28'd0, item_i.ch[3:0]};
          end else begin
            close_v          = 1'b1;
            close_res.kind   = K_NUM;
            close_res.number = acc_q;
          end
        end
        MODE_IDENT: begin
          if (item_i.cls == CL_ALPHA || item_i.cls == CL_DIGIT) begin
            if (ilen_q < MaxLen) begin
              tail_v             = 1'b1;
              tail_res.kind      = K_ICHAR;
              tail_res.text_char = item_i.ch;
              if (ilen_q < KwLen) kwin_d = {kwin_q[39:0], item_i.ch};
              ilen_d = ilen_q + 1'b1;
            end
          end else begin
            close_v        = 1'b1;
            close_res.kind = id_kind;
          end
        end
        MODE_EQ, MODE_LT, MODE_GT: begin
          close_v = 1'b1;
          if (item_i.cls == CL_EQ) begin
            close_res.kind = (mode_q == MODE_EQ) ? K_EQ : (mode_q == MODE_LT) ? K_LE : K_GE;
            mode_d = MODE_IDLE;
          end else begin
            close_res.kind = (mode_q == MODE_EQ) ? K_ASSIGN :
                             (mode_q == MODE_LT) ? K_LT : K_GT;
          end
        end
        MODE_BANG: begin
          close_v = 1'b1;
          if (item_i.cls == CL_EQ) begin
            close_res.kind = K_NE;
            mode_d = MODE_IDLE;
          end else begin
            close_res.kind = K_ERR;
            mode_d = MODE_SILENT;
          end
        end
        default: ;
      endcase
      // the closing byte starts the next token, unless it was consumed above
      if ((mode_q == MODE_IDLE) ||
          (mode_q == MODE_NUM && item_i.cls != CL_DIGIT) ||
          (mode_q == MODE_IDENT && item_i.cls != CL_ALPHA && item_i.cls != CL_DIGIT) ||
          ((mode_q == MODE_EQ || mode_q == MODE_LT || mode_q == MODE_GT) &&
           item_i.cls != CL_EQ)) begin
        mode_d   = f_mode;
        acc_d    = f_acc;
        ilen_d   = f_ilen;
        kwin_d   = f_kwin;
        line_d   = f_line;
        tline_d  = f_tline;
        tail_v   = f_v;
        tail_res = f_res;
      end
    end
  end

  // the close result, if any, is sent first, then the tail
  always_comb begin
    wr_last = phase_q || !(close_v && tail_v);
    wr_res  = (phase_q || !close_v) ? tail_res : close_res;
    wr_res.last = wr_last;
    out_push   = 1'b0;
    item_pop_o = 1'b0;
    phase_d    = phase_q;
    if (item_valid) begin
      if (!close_v && !tail_v) begin
        item_pop_o = 1'b1;
      end else if (!out_full) begin
        out_push   = 1'b1;
        item_pop_o = wr_last;
        phase_d    = !wr_last;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      acc_q   <= '0;
      ilen_q  <= '0;
      kwin_q  <= '0;
      line_q  <= 16'd1;
      tline_q <= 16'd1;
      phase_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      if (item_pop_o) begin
        mode_q  <= mode_d;
        acc_q   <= acc_d;
        ilen_q  <= ilen_d;
        kwin_q  <= kwin_d;
        line_q  <= line_d;
        tline_q <= tline_d;
      end
    end
  end

  cst_fifo #(
    .Width($bits(res_t)),
    .Depth(2)
  ) u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (out_push),
    .wdata_i(wr_res),
    .full_o (out_full),
    .pop_i  (pop_i),
    .rdata_o(res_o),
    .empty_o(empty_o)
  );

endmodule

FILE: design/c_subset_tokenizer.sv
// top level of the c subset tokenizer: front classifier, scanner back end
// depends on cst_pkg, cst_fifo, cst_front and cst_back
`timescale 1ns / 1ps

// channel  handshake     payload
// source   push / full   cmd_i, ch_i
// tokens   pop / empty   kind_o, number_o, text_char_o, line_o, last_o
//
// a word giving one result or none is popped with that write; one giving two writes
// close then tail, as the scanner makes a single result write per cycle while the token queue has room
// a two-entry queue on each side lets source and token sides stall on their own
// after reset the line count is one and the scanner is idle; no clearing pass

module c_subset_tokenizer import cst_pkg::*; #(
  parameter int MAX_IDENT_CHARS = 31
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic        cmd_i,
  input  logic [7:0]  ch_i,
  output logic        empty,
  input  logic        pop,
  output logic [4:0]  kind_o,
  output logic [31:0] number_o,
  output logic [7:0]  text_char_o,
  output logic [15:0] line_o,
  output logic        last_o
);

  item_t item;
  logic  item_empty, item_pop;
  res_t  res;

  cst_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (cmd_i),
    .ch_i   (ch_i),
    .full_o (full),
    .pop_i  (item_pop),
    .item_o (item),
    .empty_o(item_empty)
  );

  cst_back #(
    .MAX_IDENT_CHARS(MAX_IDENT_CHARS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item),
    .item_empty_i(item_empty),
    .item_pop_o  (item_pop),
    .pop_i       (pop),
    .res_o       (res),
    .empty_o     (empty)
  );

  assign kind_o      = res.kind;
  assign number_o    = res.number;
  assign text_char_o = res.text_char;
  assign line_o      = res.line;
  assign last_o      = res.last;

endmodule
